/* rtl/tsd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_pkg: shared types and constants of the 3-of-6 symbol decoder
// entry format between front and back, status codes, symbol table
// ----------------------------------------------------------------------------
package tsd_pkg;

  localparam int MAX_OUT_BYTES_DEF = 255;
  localparam int SKIP_W            = 12;
  localparam int RAW_W             = 8;
  localparam int BITN_W            = 4;
  localparam int CNT_W             = 8;
  localparam int SYM_W             = 6;

  localparam logic [SKIP_W-1:0] SKIP_BITS_RST     = '0;
  localparam logic [CNT_W-1:0]  MAX_OUT_BYTES_RST = 8'hFF;

  typedef enum logic [0:0] {
    CFG_SKIP_BITS     = 1'b0,
    CFG_MAX_OUT_BYTES = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_FULL    = 3'd2,
    ST_ODD     = 3'd3,
    ST_NO_DATA = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    STOP_NONE    = 2'd0,
    STOP_INVALID = 2'd1,
    STOP_FULL    = 2'd2
  } stop_t;

  // data bits left after skipping, left aligned
  typedef struct packed {
    logic [RAW_W-1:0]  bits;
    logic [BITN_W-1:0] nbits;
    logic              last;
    logic              no_data;
  } tsd_entry_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] nib;
  } sym_lkp_t;

  localparam logic [SYM_W-1:0] SYM_CODE [16] = '{
    6'h16, 6'h0D, 6'h0E, 6'h0B, 6'h1C, 6'h19, 6'h1A, 6'h13,
    6'h2C, 6'h25, 6'h26, 6'h23, 6'h34, 6'h31, 6'h32, 6'h29
  };

  function automatic sym_lkp_t sym_lookup(input logic [SYM_W-1:0] sym);
    sym_lkp_t r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (SYM_CODE[i] == sym) begin
        r.hit = 1'b1;
        r.nib = 4'(i);
      end
    end
    return r;
  endfunction

endpackage

/* rtl/tsd_channels_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd channel interfaces
// valid/ready channels for raw input beats and decoded result beats
// ----------------------------------------------------------------------------
interface tsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;
  logic [3:0] raw_len;
  logic       last;

  modport source (output valid, raw_byte, raw_len, last, input ready);
  modport sink   (input valid, raw_byte, raw_len, last, output ready);
endinterface

interface tsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       done_res;
  logic [2:0] status;
  logic [7:0] byte_count;

  modport source (output valid, data_byte, byte_valid, done_res, status, byte_count,
                  input ready);
  modport sink   (input valid, data_byte, byte_valid, done_res, status, byte_count,
                  output ready);
endinterface

/* rtl/tsd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_front: input stage
// accepts raw beats, strips the leading skip bits and tracks frame data
// ----------------------------------------------------------------------------
module tsd_front import tsd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  tsd_in_if.sink            in_ch,
  input  logic [SKIP_W-1:0] skip_bits,
  output logic              push_valid,
  input  logic              push_ready,
  output tsd_entry_t        push_data
);

  logic              seen_r, seen_nxt;
  logic              any_r, any_nxt;
  logic [SKIP_W-1:0] skip_rem_r, skip_rem_nxt;

  logic [BITN_W-1:0] n_eff;
  logic [SKIP_W-1:0] skip_now;
  logic [BITN_W-1:0] k;
  logic [BITN_W-1:0] data_n;
  logic              any_now;
  logic              accept;

  always_comb begin
    n_eff    = (in_ch.raw_len > 4'd8) ? 4'd8 : in_ch.raw_len;
    // skip count reloads until the frame has seen a raw bit
    skip_now = seen_r ? skip_rem_r : skip_bits;
    if (skip_now >= {{(SKIP_W-BITN_W){1'b0}}, n_eff}) begin
      k = n_eff;
    end else begin
      k = skip_now[BITN_W-1:0];
    end
    data_n  = n_eff - k;
    any_now = any_r | (data_n != '0);

    push_valid        = in_ch.valid;
    in_ch.ready       = push_ready;
    push_data.bits    = in_ch.raw_byte << k;
    push_data.nbits   = data_n;
    push_data.last    = in_ch.last;
    push_data.no_data = ~any_now;

    accept       = in_ch.valid & push_ready;
    seen_nxt     = seen_r;
    any_nxt      = any_r;
    skip_rem_nxt = skip_rem_r;
    if (accept) begin
      if (in_ch.last) begin
        seen_nxt     = 1'b0;
        any_nxt      = 1'b0;
        skip_rem_nxt = '0;
      end else begin
        seen_nxt     = seen_r | (n_eff != '0);
        any_nxt      = any_now;
        skip_rem_nxt = skip_now - {{(SKIP_W-BITN_W){1'b0}}, k};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= 1'b0;
      any_r      <= 1'b0;
      skip_rem_r <= '0;
    end else begin
      seen_r     <= seen_nxt;
      any_r      <= any_nxt;
      skip_rem_r <= skip_rem_nxt;
    end
  end

endmodule

/* rtl/tsd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_queue: two-entry queue
// decouples the input stage from the symbol decode stage
// ----------------------------------------------------------------------------
module tsd_queue import tsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  tsd_entry_t push_data,
  output logic       pop_valid,
  input  logic       pop,
  output tsd_entry_t pop_data
);

  tsd_entry_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       do_pop;

  always_comb begin
    push_ready = (count_r != 2'd2);
    pop_valid  = (count_r != 2'd0);
    pop_data   = mem_r[rd_ptr_r];
    push       = push_valid & push_ready;
    do_pop     = pop & pop_valid;
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* rtl/tsd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_back: symbol decode stage
// assembles 6-bit symbols, maps them to nibbles, pairs bytes, reports status
// ----------------------------------------------------------------------------
module tsd_back import tsd_pkg::*; #(
  parameter int MAX_OUT_BYTES = MAX_OUT_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  tsd_entry_t       q_data,
  output logic             q_pop,
  input  logic [CNT_W-1:0] max_out_bytes,
  tsd_out_if.source        out_ch
);

  // frame state
  logic [4:0]       buf_r, buf_nxt;
  logic [2:0]       held_r, held_nxt;
  logic [3:0]       up_r, up_nxt;
  logic             have_r, have_nxt;
  logic [CNT_W-1:0] bytes_r, bytes_nxt;
  stop_t            stop_r, stop_nxt;

  // output register
  logic             out_valid_r;
  logic [7:0]       data_byte_r;
  logic             byte_valid_r;
  logic             done_r;
  logic [2:0]       status_r;
  logic [CNT_W-1:0] byte_count_r;

  logic [15:0]      cap;
  logic [CNT_W-1:0] lim;
  logic [SYM_W-1:0] sym_v;
  sym_lkp_t         lk;
  logic             got;
  logic [7:0]       bval;
  status_t          st;
  logic             res;

  always_comb begin
    cap = 16'(MAX_OUT_BYTES);
    lim = ({8'b0, max_out_bytes} > cap) ? cap[CNT_W-1:0] : max_out_bytes;

    buf_nxt   = buf_r;
    held_nxt  = held_r;
    up_nxt    = up_r;
    have_nxt  = have_r;
    bytes_nxt = bytes_r;
    stop_nxt  = stop_r;
    got       = 1'b0;
    bval      = '0;
    sym_v     = '0;
    lk        = '0;
    // bit serial walk over at most eight data bits
    for (int i = 0; i < 8; i++) begin
      if ((4'(i) < q_data.nbits) && (stop_nxt == STOP_NONE)) begin
        sym_v = {buf_nxt, q_data.bits[3'(7 - i)]};
        if (held_nxt < 3'd5) begin
          buf_nxt  = sym_v[4:0];
          held_nxt = held_nxt + 3'd1;
        end else begin
          buf_nxt  = '0;
          held_nxt = '0;
          lk       = sym_lookup(sym_v);
          if (!lk.hit) begin
            stop_nxt = STOP_INVALID;
          end else if (!have_nxt) begin
            up_nxt   = lk.nib;
            have_nxt = 1'b1;
          end else if (bytes_nxt >= lim) begin
            stop_nxt = STOP_FULL;
          end else begin
            bval      = {up_nxt, lk.nib};
            got       = 1'b1;
            bytes_nxt = bytes_nxt + 8'd1;
            have_nxt  = 1'b0;
          end
        end
      end
    end

    if (q_data.no_data) begin
      st = ST_NO_DATA;
    end else begin
      unique case (stop_nxt)
        STOP_INVALID: st = ST_INVALID;
        STOP_FULL:    st = ST_FULL;
        STOP_NONE:    st = ((bytes_nxt == '0) || have_nxt) ? ST_ODD : ST_OK;
        default:      st = ST_OK;
      endcase
    end

    res   = got | q_data.last;
    q_pop = q_valid & (~out_valid_r | out_ch.ready);

    out_ch.valid      = out_valid_r;
    out_ch.data_byte  = data_byte_r;
    out_ch.byte_valid = byte_valid_r;
    out_ch.done_res   = done_r;
    out_ch.status     = status_r;
    out_ch.byte_count = byte_count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r       <= '0;
      held_r      <= '0;
      up_r        <= '0;
      have_r      <= 1'b0;
      bytes_r     <= '0;
      stop_r      <= STOP_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        out_valid_r <= res;
        if (q_data.last) begin
          buf_r   <= '0;
          held_r  <= '0;
          up_r    <= '0;
          have_r  <= 1'b0;
          bytes_r <= '0;
          stop_r  <= STOP_NONE;
        end else begin
          buf_r   <= buf_nxt;
          held_r  <= held_nxt;
          up_r    <= up_nxt;
          have_r  <= have_nxt;
          bytes_r <= bytes_nxt;
          stop_r  <= stop_nxt;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && res) begin
      data_byte_r  <= bval;
      byte_valid_r <= got;
      done_r       <= q_data.last;
      status_r     <= q_data.last ? st : ST_OK;
      byte_count_r <= q_data.last ? bytes_nxt : '0;
    end
  end

  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= 3'd5)
    else $error("symbol bit count out of range");

  a_mid_frame_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !done_r |-> status_r == ST_OK && byte_count_r == '0 && byte_valid_r)
    else $error("mid-frame result without byte or with status");

  a_no_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !byte_valid_r |-> data_byte_r == '0)
    else $error("data byte not zero without byte");

  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_data.last |=> held_r == '0 && bytes_r == '0 && !have_r && stop_r == STOP_NONE)
    else $error("frame state not cleared after last beat");

endmodule

/* rtl/three_of_six_symbol_decoder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_of_six_symbol_decoder_core: 3-of-6 line code decoder
// raw bits in, msb first; decoded bytes and a frame status out
// ----------------------------------------------------------------------------
// a result beat is held in a queue entry and then in the output register
//   before it is presented
// throughput: one input beat per cycle while the output side takes results;
//   the decode stage handles all eight bits of a beat combinationally
// a two-entry queue between input stage and decode stage; the output
//   register takes a new result in the cycle the old one is taken
// reset: synchronous active low; clears frame state and queue, loads the
//   register defaults (skip 0, byte limit 255); no clearing pass
module three_of_six_symbol_decoder_core import tsd_pkg::*; #(
  parameter int MAX_OUT_BYTES = MAX_OUT_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  tsd_in_if.sink            in_ch,
  tsd_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [SKIP_W-1:0] cfg_data
);

  // configuration registers
  logic [SKIP_W-1:0] skip_bits_r;
  logic [CNT_W-1:0]  max_out_bytes_r;

  // front to queue
  logic       push_valid;
  logic       push_ready;
  tsd_entry_t push_data;

  // queue to back
  logic       q_valid;
  logic       q_pop;
  tsd_entry_t q_data;

  // register writes must come only while the decoder is idle (not enforced)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_bits_r     <= SKIP_BITS_RST;
      max_out_bytes_r <= MAX_OUT_BYTES_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SKIP_BITS:     skip_bits_r     <= cfg_data;
        CFG_MAX_OUT_BYTES: max_out_bytes_r <= cfg_data[CNT_W-1:0];
        default:           ;
      endcase
    end
  end

  // input stage: clamp bit count, drop skipped bits, flag frames with no data
  tsd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .skip_bits  (skip_bits_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // short queue so either side can stall on its own
  tsd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  // decode stage: symbols to nibbles, bytes out, status on the last beat
  tsd_back #(
    .MAX_OUT_BYTES (MAX_OUT_BYTES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .max_out_bytes (max_out_bytes_r),
    .out_ch        (out_ch)
  );

endmodule
